/* hdl/pbiw_pkg.sv */
// Shared types, constants and helper functions for the pair/block incidence walker.
`timescale 1ns / 1ps
package pbiw_pkg;

  // Point set size and derived widths
  localparam int MAX_POINTS = 16;
  localparam int PAIR_SIZE  = 2;
  localparam int SET_W      = MAX_POINTS;
  localparam int SET_W1     = SET_W + 1;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CFG_W      = 5;
  localparam int ROW_W      = 7;
  localparam int COL_W      = 14;

  // Configuration register indexes
  localparam logic CFG_NUM_POINTS = 1'b0;
  localparam logic CFG_BLOCK_SIZE = 1'b1;

  // One result transfer
  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic [SET_W-1:0] pair_set;
    logic [SET_W-1:0] block_set;
    logic             entry_one;
    logic             last;
    logic             finished;
  } res_t;

  // Successor of a subset and whether the subset is the final one
  typedef struct packed {
    logic [SET_W-1:0] subset;
    logic             is_last;
  } succ_t;

  // Point count clamped to the bitmap width
  function automatic logic [CFG_W-1:0] eff_points(input logic [CFG_W-1:0] n);
    return (n > CFG_W'(MAX_POINTS)) ? CFG_W'(MAX_POINTS) : n;
  endfunction

  // Bitmap with the lowest n bits set
  function automatic logic [SET_W-1:0] low_mask(input logic [CFG_W-1:0] n);
    logic [SET_W1-1:0] sh;
    sh = SET_W1'(1) << n;
    return SET_W'(sh - SET_W1'(1));
  endfunction

  // Position of the single set bit of a one-hot word
  function automatic logic [IDX_W-1:0] onehot_idx(input logic [SET_W-1:0] c);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < SET_W; i++) begin
      if (c[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

/* hdl/pbiw_next_subset.sv */
// Next same-weight bitmap (colex successor) and final-subset detection.
`timescale 1ns / 1ps
module pbiw_next_subset (
  input  logic [pbiw_pkg::SET_W-1:0] cur,
  input  logic [pbiw_pkg::CFG_W-1:0] points,
  output pbiw_pkg::succ_t            succ
);
  import pbiw_pkg::*;

  logic [SET_W-1:0]  low_bit;
  logic [SET_W1-1:0] ripple;
  logic [SET_W1-1:0] moved;
  logic [SET_W1-1:0] nxt_wide;
  logic [IDX_W-1:0]  tz;

  // Isolate lowest set bit, ripple it up, refill the low ones
  always_comb begin
    low_bit  = cur & (~cur + SET_W'(1));
    ripple   = SET_W1'(cur) + SET_W1'(low_bit);
    moved    = (ripple ^ SET_W1'(cur)) >> 2;
    tz       = onehot_idx(low_bit);
    nxt_wide = ripple | (moved >> tz);
  end

  // Final when empty or when the successor leaves the point range
  assign succ.subset  = nxt_wide[SET_W-1:0];
  assign succ.is_last = (cur == '0) || ((nxt_wide >> points) != '0);

endmodule

/* hdl/pbiw_out_skid.sv */
// Output register with a skid stage that takes one further input transfer under stall.
`timescale 1ns / 1ps
module pbiw_out_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pbiw_pkg::res_t  push_data,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output pbiw_pkg::res_t  out_data
);
  import pbiw_pkg::*;

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t main_r,   main_nxt;
  res_t skid_r,   skid_nxt;

  assign push_ready = !skid_v_r;
  assign out_valid  = main_v_r;
  assign out_data   = main_r;

  // Main slot refills from skid first, then from a new push
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

/* hdl/pair_block_incidence_walker_core.sv */
// Top level: walks pair-by-block incidence positions, one per input transfer.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_ready, in_restart          | in
//   result  | out_valid, out_ready, out_row_index ... | out
//   config  | cfg_we, cfg_index, cfg_data             | in
//
// One input transfer per cycle while in_ready is high; its result is registered in the output or skid register.
// The walk state updates through the combinational colex successor logic.
// Reset sets num_points=2, block_size=1 and puts the walk at its first position.
// A stalled result channel parks up to two results (output + skid register);
// in_ready drops only when both are full.
`timescale 1ns / 1ps
module pair_block_incidence_walker_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pbiw_pkg::ROW_W-1:0] out_row_index,
  output logic [pbiw_pkg::COL_W-1:0] out_column_index,
  output logic [pbiw_pkg::SET_W-1:0] out_pair_set,
  output logic [pbiw_pkg::SET_W-1:0] out_block_set,
  output logic                       out_entry_one,
  output logic                       out_last,
  output logic                       out_finished,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pbiw_pkg::CFG_W-1:0] cfg_data
);
  import pbiw_pkg::*;

  // Configuration and walk state
  logic [CFG_W-1:0] num_points_r, num_points_nxt;
  logic [CFG_W-1:0] block_size_r, block_size_nxt;
  logic [SET_W-1:0] pair_r, pair_nxt;
  logic [SET_W-1:0] block_r, block_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             done_r, done_nxt;

  logic             accept;
  logic [CFG_W-1:0] v_cur, v_new;
  logic [SET_W-1:0] pair_cur, block_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_cur;
  logic             done_cur;
  succ_t            pair_succ, block_succ;
  res_t             res;
  res_t             out_data;

  assign accept = in_valid && in_ready;
  assign v_cur  = eff_points(num_points_r);

  // Walk position seen by this item, after an optional restart
  always_comb begin
    if (in_restart) begin
      pair_cur  = low_mask(CFG_W'(PAIR_SIZE));
      block_cur = low_mask((block_size_r <= v_cur) ? block_size_r : v_cur);
      row_cur   = '0;
      col_cur   = '0;
      done_cur  = (v_cur < CFG_W'(PAIR_SIZE)) || (block_size_r > v_cur);
    end else begin
      pair_cur  = pair_r;
      block_cur = block_r;
      row_cur   = row_r;
      col_cur   = col_r;
      done_cur  = done_r;
    end
  end

  pbiw_next_subset u_pair_succ (
    .cur    (pair_cur),
    .points (v_cur),
    .succ   (pair_succ)
  );

  pbiw_next_subset u_block_succ (
    .cur    (block_cur),
    .points (v_cur),
    .succ   (block_succ)
  );

  // Result of this position
  always_comb begin
    if (done_cur) begin
      res          = '0;
      res.finished = 1'b1;
    end else begin
      res.row_index    = row_cur;
      res.column_index = col_cur;
      res.pair_set     = pair_cur;
      res.block_set    = block_cur;
      res.entry_one    = ((pair_cur & block_cur) == pair_cur);
      res.last         = block_succ.is_last && pair_succ.is_last;
      res.finished     = 1'b0;
    end
  end

  // Config writes restart the walk under the new values; items advance it
  always_comb begin
    num_points_nxt = num_points_r;
    block_size_nxt = block_size_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_POINTS: num_points_nxt = cfg_data;
        CFG_BLOCK_SIZE: block_size_nxt = cfg_data;
        default: ;
      endcase
    end
    v_new = eff_points(num_points_nxt);

    pair_nxt  = pair_r;
    block_nxt = block_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    done_nxt  = done_r;
    if (cfg_we) begin
      pair_nxt  = low_mask(CFG_W'(PAIR_SIZE));
      block_nxt = low_mask((block_size_nxt <= v_new) ? block_size_nxt : v_new);
      row_nxt   = '0;
      col_nxt   = '0;
      done_nxt  = (v_new < CFG_W'(PAIR_SIZE)) || (block_size_nxt > v_new);
    end else if (accept) begin
      pair_nxt  = pair_cur;
      block_nxt = block_cur;
      row_nxt   = row_cur;
      col_nxt   = col_cur;
      done_nxt  = done_cur;
      if (!done_cur) begin
        if (!block_succ.is_last) begin
          block_nxt = block_succ.subset;
          col_nxt   = col_cur + COL_W'(1);
        end else if (!pair_succ.is_last) begin
          pair_nxt  = pair_succ.subset;
          row_nxt   = row_cur + ROW_W'(1);
          block_nxt = low_mask(block_size_r);
          col_nxt   = '0;
        end else begin
          done_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= CFG_W'(2);
      block_size_r <= CFG_W'(1);
      pair_r       <= low_mask(CFG_W'(PAIR_SIZE));
      block_r      <= low_mask(CFG_W'(1));
      row_r        <= '0;
      col_r        <= '0;
      done_r       <= 1'b0;
    end else begin
      num_points_r <= num_points_nxt;
      block_size_r <= block_size_nxt;
      pair_r       <= pair_nxt;
      block_r      <= block_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      done_r       <= done_nxt;
    end
  end

  // Result buffering
  pbiw_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_row_index    = out_data.row_index;
  assign out_column_index = out_data.column_index;
  assign out_pair_set     = out_data.pair_set;
  assign out_block_set    = out_data.block_set;
  assign out_entry_one    = out_data.entry_one;
  assign out_last         = out_data.last;
  assign out_finished     = out_data.finished;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the pair/block incidence walker core.
`timescale 1ns / 1ps
module tb;
  import pbiw_pkg::*;

  // Scoreboard: tracks the walk position and holds the results still owed
  class incidence_scoreboard;
    logic [CFG_W-1:0] npts;
    logic [CFG_W-1:0] bsize;
    logic [63:0]      pair_bits;
    logic [63:0]      block_bits;
    int unsigned      row_cnt;
    int unsigned      col_cnt;
    bit               done;
    res_t             owed[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      walk_ends;
    int unsigned      finished_seen;

    function int unsigned points_in_use();
      return (npts > CFG_W'(MAX_POINTS)) ? MAX_POINTS : int'(npts);
    endfunction

    function logic [63:0] ones(int unsigned n);
      return (64'd1 << n) - 64'd1;
    endfunction

    // Next larger bitmap of equal weight; zero stays zero
    function logic [63:0] colex_next(logic [63:0] x);
      logic [63:0] lowest;
      logic [63:0] sum;
      logic [63:0] ripple;
      int          tz;
      if (x == 64'd0) return 64'd0;
      lowest = x & (~x + 64'd1);
      sum    = x + lowest;
      ripple = (sum ^ x) >> 2;
      tz     = 0;
      while (tz < 63 && lowest[tz] == 1'b0) tz++;
      return sum | (ripple >> tz);
    endfunction

    function void restart_walk();
      int unsigned v;
      int unsigned k;
      v          = points_in_use();
      k          = bsize;
      pair_bits  = ones(PAIR_SIZE);
      block_bits = ones((k <= v) ? k : v);
      row_cnt    = 0;
      col_cnt    = 0;
      done       = (v < PAIR_SIZE) || (k > v);
    endfunction

    function void reset_walk();
      npts  = CFG_W'(2);
      bsize = CFG_W'(1);
      restart_walk();
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_NUM_POINTS) npts = val;
      else bsize = val;
      restart_walk();
    endfunction

    // One accepted step: report the current position, then advance
    function void note_step(logic restart);
      res_t        e;
      logic [63:0] nxt_block;
      logic [63:0] nxt_pair;
      bit          block_end;
      bit          pair_end;
      int unsigned v;
      v = points_in_use();
      if (restart) restart_walk();
      e = '0;
      if (done) begin
        e.finished = 1'b1;
      end else begin
        nxt_block = colex_next(block_bits);
        nxt_pair  = colex_next(pair_bits);
        block_end = (block_bits == 64'd0) || ((nxt_block >> v) != 64'd0);
        pair_end  = (pair_bits == 64'd0) || ((nxt_pair >> v) != 64'd0);
        e.row_index    = ROW_W'(row_cnt);
        e.column_index = COL_W'(col_cnt);
        e.pair_set     = SET_W'(pair_bits);
        e.block_set    = SET_W'(block_bits);
        e.entry_one    = ((pair_bits & block_bits) == pair_bits);
        e.last         = block_end && pair_end;
        if (!block_end) begin
          block_bits = nxt_block;
          col_cnt++;
        end else if (!pair_end) begin
          pair_bits  = nxt_pair;
          row_cnt++;
          block_bits = ones(bsize);
          col_cnt    = 0;
        end else begin
          done = 1'b1;
        end
      end
      owed.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        report("result transfer with nothing outstanding");
      end else begin
        want = owed.pop_front();
        checked++;
        if (want.last) walk_ends++;
        if (want.finished) finished_seen++;
        check_field("row_index", got.row_index, want.row_index);
        check_field("column_index", got.column_index, want.column_index);
        check_field("pair_set", got.pair_set, want.pair_set);
        check_field("block_set", got.block_set, want.block_set);
        check_field("entry_one", got.entry_one, want.entry_one);
        check_field("last", got.last, want.last);
        check_field("finished", got.finished, want.finished);
      end
    endtask
  endclass

  localparam int STEP_TARGET = 1250;
  localparam int HOLD_AT     = 1000;
  localparam int HOLD_LEN    = 80;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_restart = 1'b0;
  logic             out_ready  = 1'b0;
  logic             cfg_we     = 1'b0;
  logic             cfg_index  = CFG_NUM_POINTS;
  logic [CFG_W-1:0] cfg_data   = '0;
  logic             in_ready;
  logic             out_valid;
  logic [ROW_W-1:0] out_row_index;
  logic [COL_W-1:0] out_column_index;
  logic [SET_W-1:0] out_pair_set;
  logic [SET_W-1:0] out_block_set;
  logic             out_entry_one;
  logic             out_last;
  logic             out_finished;

  incidence_scoreboard sb;
  res_t        seen;
  int          idle_mode    = 0;
  int unsigned steps_sent   = 0;
  int unsigned settings_run = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;

  pair_block_incidence_walker_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_pair_set     (out_pair_set),
    .out_block_set    (out_block_set),
    .out_entry_one    (out_entry_one),
    .out_last         (out_last),
    .out_finished     (out_finished),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: check each transfer, then pick next ready (random, or a long hold)
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen = '{out_row_index, out_column_index, out_pair_set, out_block_set,
                 out_entry_one, out_last, out_finished};
        sb.check_result(seen);
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && steps_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= ((idle_mode == 0) ? 81 :
                                            (idle_mode == 1) ? 19 : 0));
      end
    end
  end

  // Offer one step; valid stays up with a fixed payload until the transfer
  task automatic push_step(input logic restart);
    idle_mode = (steps_sent < 420) ? 0 : (steps_sent < 840) ? 1 : 2;
    while ($urandom_range(99) < ((idle_mode == 0) ? 19 : (idle_mode == 1) ? 81 : 0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_step(restart);
    steps_sent++;
  endtask

  // Let every owed result drain, then idle for pipeline slack
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.owed.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed.size()));
    repeat (3) @(posedge clk);
  endtask

  // Idle the block and write both registers back to back
  task automatic retarget(input logic [CFG_W-1:0] v, input logic [CFG_W-1:0] k);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_POINTS;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_register(CFG_NUM_POINTS, v);
    cfg_index <= CFG_BLOCK_SIZE;
    cfg_data  <= k;
    @(posedge clk);
    sb.set_register(CFG_BLOCK_SIZE, k);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] v;
    logic [CFG_W-1:0] k;
    int               n;
    sb = new;
    sb.reset_walk();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset setting runs to its end, then restart
    push_step(1'b0);
    push_step(1'b0);
    push_step(1'b0);
    push_step(1'b1);
    // too few points
    retarget(CFG_W'(0), CFG_W'(1));
    push_step(1'b0);
    // point count above the bitmap width, full-size blocks
    retarget(CFG_W'(31), CFG_W'(16));
    push_step(1'b1);
    push_step(1'b0);
    // empty blocks
    retarget(CFG_W'(16), CFG_W'(0));
    push_step(1'b0);
    push_step(1'b0);
    // block larger than the point set
    retarget(CFG_W'(16), CFG_W'(17));
    push_step(1'b0);
    retarget(CFG_W'(3), CFG_W'(3));
    repeat (4) push_step(1'b0);
    retarget(CFG_W'(4), CFG_W'(31));
    push_step(1'b0);
    retarget(CFG_W'(2), CFG_W'(2));
    push_step(1'b0);
    push_step(1'b0);

    // Random: mostly short complete walks, a few extreme settings
    while (steps_sent < STEP_TARGET) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       v = CFG_W'($urandom_range(1));
          1:       v = CFG_W'(16);
          default: v = CFG_W'($urandom_range(17, 31));
        endcase
        k = ($urandom_range(1) == 0) ? CFG_W'($urandom_range(31)) : CFG_W'(16);
      end else begin
        v = CFG_W'($urandom_range(2, ($urandom_range(4) == 0) ? 7 : 5));
        k = CFG_W'($urandom_range(0, int'(v) + (($urandom_range(7) == 0) ? 1 : 0)));
      end
      retarget(v, k);
      n = $urandom_range(30, 150);
      while (n > 0 && steps_sent < STEP_TARGET) begin
        push_step($urandom_range(39) == 0);
        n--;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("walked %0d steps over %0d register settings, %0d results checked",
             steps_sent, settings_run, sb.checked);
    $display("saw %0d walk ends and %0d finished reports", sb.walk_ends, sb.finished_seen);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
